// File: rtl/core/spta_pkg.sv
package spta_pkg;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned DIST_W = 14;
    localparam int unsigned POS_W  = 12;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned CFG_W  = 14;
    localparam int unsigned STEP_W = 7;

    localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SWEEP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADAPTIVE = 2'd2;

    localparam logic [CMD_W-1:0] CMD_PAN_RIGHT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAN_LEFT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TILT_UP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TILT_DOWN = 3'd4;

    localparam logic [IDX_W-1:0] REG_MODE           = 2'd0;
    localparam logic [IDX_W-1:0] REG_PAN_LOW_LIMIT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PAN_HIGH_LIMIT = 2'd2;
    localparam logic [IDX_W-1:0] REG_HALF_GAIN_DIST = 2'd3;

    localparam logic [POS_W-1:0] PAN_LOW_RESET   = 12'd600;
    localparam logic [POS_W-1:0] PAN_HIGH_RESET  = 12'd2400;
    localparam logic [DIST_W-1:0] HALF_GAIN_RESET = 14'd480;
    localparam logic [POS_W-1:0] TRACK_RESET     = 12'd500;

    localparam logic [STEP_W-1:0] MANUAL_PAN_STEP = 7'd100;
    localparam logic [POS_W-1:0]  TILT_STEP       = 12'd200;
    localparam logic [POS_W-1:0]  TILT_LOW        = 12'd600;
    localparam logic [POS_W-1:0]  TILT_HIGH       = 12'd1200;
    localparam logic [POS_W-1:0]  TILT_SWEEP      = 12'd900;

    localparam logic [POS_W-1:0] SWEEP_STEP = 12'd100;
    localparam logic [POS_W-1:0] SWEEP_TOP  = 12'd2400;
    localparam logic [POS_W-1:0] SWEEP_BASE = 12'd500;
    localparam logic [POS_W-1:0] SWEEP_MIN  = 12'd400;
    localparam logic [POS_W-1:0] SWEEP_MAX  = 12'd2500;

    localparam logic [DIST_W-1:0] VALID_LOW  = 14'd16;
    localparam logic [DIST_W-1:0] VALID_HIGH = 14'd6400;

    localparam logic signed [DIST_W:0] DIFF_NEAR = 15'sd16;
    localparam logic signed [DIST_W:0] DIFF_FAR  = 15'sd112;

    localparam logic [STEP_W-1:0] STEP_NEAR      = 7'd40;
    localparam logic [STEP_W-1:0] STEP_FAR       = 7'd80;
    localparam logic [STEP_W-1:0] STEP_NEAR_HALF = 7'd20;
    localparam logic [STEP_W-1:0] STEP_FAR_HALF  = 7'd40;

    typedef struct packed {
        logic [CMD_W-1:0]  manual_command;
        logic [DIST_W-1:0] dist_a;
        logic [DIST_W-1:0] dist_b;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] pan_position;
        logic [POS_W-1:0] tilt_position;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pan_low_limit;
        logic [POS_W-1:0]  pan_high_limit;
        logic [DIST_W-1:0] half_gain_distance;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] pan_track;
        logic [POS_W-1:0] tilt_track;
        logic [POS_W-1:0] sweep_angle;
        logic             sweep_descending;
    } track_t;

endpackage

// File: rtl/core/spta_item_if.sv
interface spta_item_if import spta_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  manual_command;
    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;

    modport source (output valid, output manual_command, output dist_a, output dist_b,
                    input ready);
    modport sink (input valid, input manual_command, input dist_a, input dist_b,
                  output ready);

endinterface

// File: rtl/core/spta_result_if.sv
interface spta_result_if import spta_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pan_position;
    logic [POS_W-1:0] tilt_position;

    modport source (output valid, output pan_position, output tilt_position, input ready);
    modport sink (input valid, input pan_position, input tilt_position, output ready);

endinterface

// File: rtl/core/spta_cfg_if.sv
interface spta_cfg_if import spta_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

// File: rtl/core/spta_step.sv
module spta_step import spta_pkg::*; (
    input  cfg_t    cfg,
    input  track_t  track,
    input  item_t   item,
    output track_t  track_next,
    output logic    emit,
    output result_t result
);

    function automatic logic [POS_W-1:0] pan_up(
        input logic [POS_W-1:0]  pan,
        input logic [STEP_W-1:0] step,
        input logic [POS_W-1:0]  high
    );
        logic [POS_W:0] sum;
        sum = {1'b0, pan} + {{(POS_W+1-STEP_W){1'b0}}, step};
        if (sum >= {1'b0, high})
            return high;
        return sum[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pan_down(
        input logic [POS_W-1:0]  pan,
        input logic [STEP_W-1:0] step,
        input logic [POS_W-1:0]  low
    );
        logic [POS_W:0] bound;
        bound = {1'b0, low} + {{(POS_W+1-STEP_W){1'b0}}, step};
        if ({1'b0, pan} <= bound)
            return low;
        return pan - {{(POS_W-STEP_W){1'b0}}, step};
    endfunction

    function automatic logic reading_ok(input logic [DIST_W-1:0] d);
        return (d > VALID_LOW) && (d < VALID_HIGH);
    endfunction

    logic                   ok_a;
    logic                   ok_b;
    logic                   half;
    logic signed [DIST_W:0] diff;
    logic [STEP_W-1:0]      step_near;
    logic [STEP_W-1:0]      step_far;
    logic [POS_W-1:0]       angle_rise;
    logic                   desc_rise;
    logic [POS_W:0]         tilt_sum;

    assign ok_a = reading_ok(item.dist_a);
    assign ok_b = reading_ok(item.dist_b);
    assign half = (item.dist_a > cfg.half_gain_distance)
               && (item.dist_b > cfg.half_gain_distance);
    assign diff = $signed({1'b0, item.dist_a}) - $signed({1'b0, item.dist_b});
    assign step_near = half ? STEP_NEAR_HALF : STEP_NEAR;
    assign step_far  = half ? STEP_FAR_HALF : STEP_FAR;
    assign tilt_sum  = {1'b0, track.tilt_track} + {1'b0, TILT_STEP};

    // rising half of the sweep bounce
    always_comb
    begin
        angle_rise = track.sweep_angle;
        desc_rise  = track.sweep_descending;
        if (!track.sweep_descending)
        begin
            if (track.sweep_angle <= SWEEP_TOP)
                angle_rise = track.sweep_angle + SWEEP_STEP;
            else
            begin
                angle_rise = SWEEP_TOP;
                desc_rise  = 1'b1;
            end
        end
    end

    always_comb
    begin
        track_next = track;
        emit       = 1'b0;
        result     = '0;
        unique case (cfg.mode)
            MODE_MANUAL:
            begin
                emit = 1'b1;
                case (item.manual_command)
                    CMD_PAN_RIGHT:
                        track_next.pan_track = pan_down(track.pan_track, MANUAL_PAN_STEP,
                                                        cfg.pan_low_limit);
                    CMD_PAN_LEFT:
                        track_next.pan_track = pan_up(track.pan_track, MANUAL_PAN_STEP,
                                                      cfg.pan_high_limit);
                    CMD_TILT_UP:
                        track_next.tilt_track = (tilt_sum > {1'b0, TILT_HIGH})
                                              ? TILT_HIGH : tilt_sum[POS_W-1:0];
                    CMD_TILT_DOWN:
                        track_next.tilt_track = (track.tilt_track < TILT_LOW + TILT_STEP)
                                              ? TILT_LOW : track.tilt_track - TILT_STEP;
                    default:
                        emit = 1'b0;
                endcase
                result.pan_position  = track_next.pan_track;
                result.tilt_position = track_next.tilt_track;
            end
            MODE_SWEEP:
            begin
                if (ok_a)
                begin
                    emit = 1'b1;
                    track_next.sweep_angle      = angle_rise;
                    track_next.sweep_descending = desc_rise;
                    if (desc_rise)
                    begin
                        if (angle_rise >= SWEEP_BASE)
                            track_next.sweep_angle = angle_rise - SWEEP_STEP;
                        else
                        begin
                            track_next.sweep_angle      = SWEEP_BASE;
                            track_next.sweep_descending = 1'b0;
                        end
                    end
                    result.pan_position  = track_next.sweep_angle;
                    result.tilt_position = TILT_SWEEP;
                end
            end
            MODE_ADAPTIVE:
            begin
                if (ok_a && ok_b)
                begin
                    emit = 1'b1;
                    if (diff > DIFF_NEAR && diff < DIFF_FAR)
                        track_next.pan_track = pan_up(track.pan_track, step_near,
                                                      cfg.pan_high_limit);
                    else if (diff < -DIFF_NEAR && diff > -DIFF_FAR)
                        track_next.pan_track = pan_down(track.pan_track, step_near,
                                                        cfg.pan_low_limit);
                    else if (diff < -DIFF_FAR)
                        track_next.pan_track = pan_down(track.pan_track, step_far,
                                                        cfg.pan_low_limit);
                    else if (diff > DIFF_FAR)
                        track_next.pan_track = pan_up(track.pan_track, step_far,
                                                      cfg.pan_high_limit);
                    result.pan_position  = track_next.pan_track;
                    result.tilt_position = track.tilt_track;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/servo_pan_tilt_aim_controller.sv
// Pan/tilt aim controller. Each accepted request (manual command plus two sonar
// distances) is latched in an input register, the next pan, tilt and sweep
// positions are computed combinationally against the position registers, and the
// result lands in an output register. Throughput is one request per cycle while
// the result side keeps up; a result passes the input register and then the
// output register. The position register feedback through the step logic sets
// that rate. Requests that produce no result (no command, invalid sonar reading,
// unused mode) still update nothing and leave the output alone. Configuration
// writes are always ready and take effect on the next request.
module servo_pan_tilt_aim_controller import spta_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    spta_item_if.sink     sample,
    spta_result_if.source result,
    spta_cfg_if.sink      cfg
);

    cfg_t    cfg_reg;
    track_t  track_reg;
    track_t  track_next;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    logic    s1_fire;
    logic    step_emit;
    result_t step_result;
    track_t  step_track;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode               <= MODE_MANUAL;
            cfg_reg.pan_low_limit      <= PAN_LOW_RESET;
            cfg_reg.pan_high_limit     <= PAN_HIGH_RESET;
            cfg_reg.half_gain_distance <= HALF_GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MODE:           cfg_reg.mode               <= cfg.data[MODE_W-1:0];
                REG_PAN_LOW_LIMIT:  cfg_reg.pan_low_limit      <= cfg.data[POS_W-1:0];
                REG_PAN_HIGH_LIMIT: cfg_reg.pan_high_limit     <= cfg.data[POS_W-1:0];
                REG_HALF_GAIN_DIST: cfg_reg.half_gain_distance <= cfg.data[DIST_W-1:0];
                default:            cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    spta_step u_step (
        .cfg        (cfg_reg),
        .track      (track_reg),
        .item       (s1_item_reg),
        .track_next (step_track),
        .emit       (step_emit),
        .result     (step_result)
    );

    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next  = (sample.valid && sample.ready) || (s1_valid_reg && !s1_fire);
        out_valid_next = (out_valid_reg && !result.ready) || (s1_fire && step_emit);
        track_next     = s1_fire ? step_track : track_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
            track_reg.pan_track         <= TRACK_RESET;
            track_reg.tilt_track        <= TRACK_RESET;
            track_reg.sweep_angle       <= TRACK_RESET;
            track_reg.sweep_descending  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            track_reg     <= track_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_item_reg.manual_command <= sample.manual_command;
            s1_item_reg.dist_a         <= sample.dist_a;
            s1_item_reg.dist_b         <= sample.dist_b;
        end
        if (s1_fire && step_emit)
            out_data_reg <= step_result;
    end

    assign result.valid         = out_valid_reg;
    assign result.pan_position  = out_data_reg.pan_position;
    assign result.tilt_position = out_data_reg.tilt_position;

    // accepted request always occupies the input stage next cycle
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> s1_valid_reg)
        else $error("accepted request lost before the step logic");

    // sweep bounce stays inside its overshoot band
    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        track_reg.sweep_angle >= SWEEP_MIN && track_reg.sweep_angle <= SWEEP_MAX)
        else $error("sweep position out of range");

    // tilt stays between its reset position and its upper clamp
    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        track_reg.tilt_track >= TRACK_RESET && track_reg.tilt_track <= TILT_HIGH)
        else $error("tilt track out of range");

    // a pending result is never overwritten by the step logic
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !s1_fire)
        else $error("step fired while result was stalled");

    // no state change without a request in the step stage
    a_track_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |=> $stable(track_reg))
        else $error("position state changed with no request");

endmodule

// File: verif/servo_pan_tilt_aim_controller_test.sv
`timescale 1ns / 100ps

module servo_pan_tilt_aim_controller_test;
    import spta_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int HOLD_LEN      = 60;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 17;
    localparam int PHASE_ITEMS   = 100;
    localparam int PAN_MAX       = 4095;
    localparam int DIST_MAX      = 16383;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [CMD_W-1:0]  CMD_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CYCLE [3] = '{MODE_MANUAL, MODE_SWEEP, MODE_ADAPTIVE};

    logic clk;
    logic rst_n;

    spta_item_if   item_bus();
    spta_result_if aim_bus();
    spta_cfg_if    cfg_bus();

    servo_pan_tilt_aim_controller DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (item_bus),
        .result (aim_bus),
        .cfg    (cfg_bus)
    );

    item_t   pending_requests[$];
    result_t expected_aims[$];
    item_t   next_request;

    // predictor copy of the registers and the tracking state
    logic [MODE_W-1:0] cfg_mode      = MODE_MANUAL;
    logic [POS_W-1:0]  cfg_pan_low   = PAN_LOW_RESET;
    logic [POS_W-1:0]  cfg_pan_high  = PAN_HIGH_RESET;
    logic [DIST_W-1:0] cfg_half_gain = HALF_GAIN_RESET;

    int aim_pan   = int'(TRACK_RESET);
    int aim_tilt  = int'(TRACK_RESET);
    int sweep_pos = int'(TRACK_RESET);
    bit sweep_down = 1'b0;

    bit idle_on;
    bit long_hold;
    bit request_taken;
    int send_idle;
    int recv_idle;
    int hold_count;
    int quiet_cycles;
    int mismatch_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit reading_valid(int d);
        return d > int'(VALID_LOW) && d < int'(VALID_HIGH);
    endfunction

    function automatic int pan_after(int delta);
        int p;
        p = aim_pan + delta;
        if (delta > 0 && p >= int'(cfg_pan_high))
            p = int'(cfg_pan_high);
        else if (delta < 0 && p <= int'(cfg_pan_low))
            p = int'(cfg_pan_low);
        return p;
    endfunction

    function automatic bit aim_step(input item_t req, output result_t res);
        int da;
        int db;
        int diff;
        int near_step;
        int far_step;
        bit halved;
        da = int'(req.dist_a);
        db = int'(req.dist_b);
        res = '0;
        case (cfg_mode)
            MODE_MANUAL:
            begin
                case (req.manual_command)
                    CMD_PAN_RIGHT: aim_pan = pan_after(-int'(MANUAL_PAN_STEP));
                    CMD_PAN_LEFT:  aim_pan = pan_after(int'(MANUAL_PAN_STEP));
                    CMD_TILT_UP:
                    begin
                        aim_tilt = aim_tilt + int'(TILT_STEP);
                        if (aim_tilt > int'(TILT_HIGH))
                            aim_tilt = int'(TILT_HIGH);
                    end
                    CMD_TILT_DOWN:
                    begin
                        aim_tilt = aim_tilt - int'(TILT_STEP);
                        if (aim_tilt < int'(TILT_LOW))
                            aim_tilt = int'(TILT_LOW);
                    end
                    default: return 1'b0;
                endcase
                res.pan_position  = aim_pan[POS_W-1:0];
                res.tilt_position = aim_tilt[POS_W-1:0];
            end
            MODE_SWEEP:
            begin
                if (!reading_valid(da))
                    return 1'b0;
                if (!sweep_down)
                begin
                    if (sweep_pos <= int'(SWEEP_TOP))
                        sweep_pos = sweep_pos + int'(SWEEP_STEP);
                    else
                    begin
                        sweep_pos = int'(SWEEP_TOP);
                        sweep_down = 1'b1;
                    end
                end
                if (sweep_down)
                begin
                    if (sweep_pos >= int'(SWEEP_BASE))
                        sweep_pos = sweep_pos - int'(SWEEP_STEP);
                    else
                    begin
                        sweep_pos = int'(SWEEP_BASE);
                        sweep_down = 1'b0;
                    end
                end
                res.pan_position  = sweep_pos[POS_W-1:0];
                res.tilt_position = TILT_SWEEP;
            end
            MODE_ADAPTIVE:
            begin
                if (!reading_valid(da) || !reading_valid(db))
                    return 1'b0;
                halved = da > int'(cfg_half_gain) && db > int'(cfg_half_gain);
                near_step = halved ? int'(STEP_NEAR_HALF) : int'(STEP_NEAR);
                far_step  = halved ? int'(STEP_FAR_HALF) : int'(STEP_FAR);
                diff = da - db;
                if (diff > int'(DIFF_NEAR) && diff < int'(DIFF_FAR))
                    aim_pan = pan_after(near_step);
                else if (diff < -int'(DIFF_NEAR) && diff > -int'(DIFF_FAR))
                    aim_pan = pan_after(-near_step);
                else if (diff < -int'(DIFF_FAR))
                    aim_pan = pan_after(-far_step);
                else if (diff > int'(DIFF_FAR))
                    aim_pan = pan_after(far_step);
                res.pan_position  = aim_pan[POS_W-1:0];
                res.tilt_position = aim_tilt[POS_W-1:0];
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // mostly well-formed requests for the mode, the rest full-range noise
    function automatic item_t make_request(logic [MODE_W-1:0] mode_now);
        item_t req;
        int offset;
        int db;
        req.manual_command = CMD_W'($urandom_range(0, 7));
        req.dist_a = DIST_W'($urandom);
        req.dist_b = DIST_W'($urandom);
        if ($urandom_range(0, 9) < 8)
        begin
            case (mode_now)
                MODE_MANUAL:
                    req.manual_command =
                        CMD_W'($urandom_range(int'(CMD_PAN_RIGHT), int'(CMD_TILT_DOWN)));
                MODE_SWEEP:
                    req.dist_a = DIST_W'($urandom_range(int'(VALID_LOW) + 1,
                                                        int'(VALID_HIGH) - 1));
                MODE_ADAPTIVE:
                begin
                    req.dist_a = DIST_W'($urandom_range(int'(VALID_LOW) + 1,
                                                        int'(VALID_HIGH) - 1));
                    offset = int'($urandom_range(0, 400)) - 200;
                    db = int'(req.dist_a) - offset;
                    if (!reading_valid(db))
                        db = int'($urandom_range(int'(VALID_LOW) + 1, int'(VALID_HIGH) - 1));
                    req.dist_b = DIST_W'(db);
                end
                default: ;
            endcase
        end
        return req;
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return PAN_MAX;
            2: return int'($urandom_range(400, 1000));
            3: return int'($urandom_range(1800, 2600));
            default: return int'($urandom_range(0, PAN_MAX));
        endcase
    endfunction

    function automatic int pick_half_gain();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return DIST_MAX;
            2: return int'($urandom_range(17, 6399));
            default: return int'($urandom_range(0, DIST_MAX));
        endcase
    endfunction

    task automatic queue_request(logic [CMD_W-1:0] cmd, int da, int db);
        item_t req;
        req.manual_command = cmd;
        req.dist_a = DIST_W'(da);
        req.dist_b = DIST_W'(db);
        pending_requests.push_back(req);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] reg_index, int value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= reg_index;
        cfg_bus.data  <= CFG_W'(value);
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_config(logic [MODE_W-1:0] mode_now, int low, int high, int half);
        write_reg(REG_MODE, int'(mode_now));
        write_reg(REG_PAN_LOW_LIMIT, low);
        write_reg(REG_PAN_HIGH_LIMIT, high);
        write_reg(REG_HALF_GAIN_DIST, half);
    endtask

    // wait until every request is in and every aim result is out
    task automatic settle();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || item_bus.valid || expected_aims.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_bus.valid || request_taken))
        begin
            if (send_idle > 0)
            begin
                send_idle--;
                item_bus.valid <= 1'b0;
            end
            else if (pending_requests.size() == 0)
                item_bus.valid <= 1'b0;
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                send_idle = $urandom_range(0, 2);
                item_bus.valid <= 1'b0;
            end
            else
            begin
                next_request = pending_requests.pop_front();
                item_bus.valid          <= 1'b1;
                item_bus.manual_command <= next_request.manual_command;
                item_bus.dist_a         <= next_request.dist_a;
                item_bus.dist_b         <= next_request.dist_b;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (long_hold)
        begin
            aim_bus.ready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_LEN)
            begin
                long_hold = 1'b0;
                hold_count = 0;
            end
        end
        else if (recv_idle > 0)
        begin
            recv_idle--;
            aim_bus.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            recv_idle = $urandom_range(0, 2);
            aim_bus.ready <= 1'b0;
        end
        else
            aim_bus.ready <= 1'b1;
    end

    // monitor, predictor and checker
    always @(posedge clk)
    begin : watch_bus
        item_t   seen;
        result_t want;
        bit      moved;
        moved = 1'b0;
        request_taken = rst_n && item_bus.valid && item_bus.ready;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                moved = 1'b1;
                case (cfg_bus.index)
                    REG_MODE:           cfg_mode      = cfg_bus.data[MODE_W-1:0];
                    REG_PAN_LOW_LIMIT:  cfg_pan_low   = cfg_bus.data[POS_W-1:0];
                    REG_PAN_HIGH_LIMIT: cfg_pan_high  = cfg_bus.data[POS_W-1:0];
                    REG_HALF_GAIN_DIST: cfg_half_gain = cfg_bus.data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (aim_bus.valid && aim_bus.ready)
            begin
                moved = 1'b1;
                if (expected_aims.size() == 0)
                begin
                    $error("unexpected result: pan_position %0d tilt_position %0d",
                           aim_bus.pan_position, aim_bus.tilt_position);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_aims.pop_front();
                    if (aim_bus.pan_position !== want.pan_position)
                    begin
                        $error("pan_position expected %0d got %0d",
                               want.pan_position, aim_bus.pan_position);
                        mismatch_count++;
                    end
                    if (aim_bus.tilt_position !== want.tilt_position)
                    begin
                        $error("tilt_position expected %0d got %0d",
                               want.tilt_position, aim_bus.tilt_position);
                        mismatch_count++;
                    end
                end
            end
            if (request_taken)
            begin
                moved = 1'b1;
                seen.manual_command = item_bus.manual_command;
                seen.dist_a = item_bus.dist_a;
                seen.dist_b = item_bus.dist_b;
                if (aim_step(seen, want))
                    expected_aims.push_back(want);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        int n;
        int count;
        int low;
        int high;
        int half;
        logic [MODE_W-1:0] mode_now;

        item_bus.valid = 1'b0;
        item_bus.manual_command = CMD_NONE;
        item_bus.dist_a = '0;
        item_bus.dist_b = '0;
        aim_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_MODE;
        cfg_bus.data = '0;
        idle_on = 1'b1;
        long_hold = 1'b0;
        request_taken = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        hold_count = 0;
        quiet_cycles = 0;
        mismatch_count = 0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // manual: every command, pan low clamp and tilt clamps, ignored codes, distance extremes
        queue_request(CMD_NONE, 0, 0);
        queue_request(CMD_PAN_RIGHT, DIST_MAX, 0);
        queue_request(CMD_PAN_LEFT, 0, DIST_MAX);
        repeat (4) queue_request(CMD_TILT_UP, 100, 100);
        repeat (4) queue_request(CMD_TILT_DOWN, 100, 100);
        queue_request(3'd5, DIST_MAX, DIST_MAX);
        queue_request(3'd6, 0, 0);
        queue_request(3'd7, DIST_MAX, 0);
        settle();

        // sweep: validity edges of sonar a
        write_reg(REG_MODE, int'(MODE_SWEEP));
        queue_request(CMD_TILT_UP, 16, 1000);
        queue_request(CMD_NONE, 17, 0);
        queue_request(CMD_PAN_LEFT, 6399, DIST_MAX);
        queue_request(CMD_NONE, 6400, 500);
        queue_request(CMD_NONE, 0, 500);
        queue_request(CMD_NONE, DIST_MAX, 500);
        settle();

        // adaptive: difference thresholds, half gain, invalid readings
        write_reg(REG_MODE, int'(MODE_ADAPTIVE));
        queue_request(CMD_PAN_LEFT, 1000, 888);
        queue_request(CMD_NONE, 1000, 1112);
        queue_request(CMD_NONE, 1000, 984);
        queue_request(CMD_NONE, 1000, 1016);
        queue_request(CMD_NONE, 1000, 887);
        queue_request(CMD_NONE, 1000, 1113);
        queue_request(CMD_NONE, 300, 250);
        queue_request(CMD_NONE, 100, 300);
        queue_request(CMD_NONE, 1000, 6400);
        settle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            mode_now = (ph == 9) ? MODE_UNUSED : MODE_CYCLE[ph % 3];
            case (ph)
                0:
                begin
                    low = 0;
                    high = PAN_MAX;
                    half = 0;
                end
                2:
                begin
                    low = PAN_MAX;
                    high = 0;
                    half = DIST_MAX;
                end
                5:
                begin
                    low = 0;
                    high = PAN_MAX;
                    half = 0;
                end
                default:
                begin
                    low = pick_limit();
                    high = pick_limit();
                    half = pick_half_gain();
                end
            endcase
            set_config(mode_now, low, high, half);
            idle_on = (ph % 5 != 4) && (ph < PHASES - 2);
            if (ph == 6)
                long_hold = 1'b1;
            count = (mode_now == MODE_UNUSED) ? 30 : PHASE_ITEMS;
            for (n = 0; n < count; n++)
                pending_requests.push_back(make_request(mode_now));
            settle();
        end

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: servo_pan_tilt_aim_controller.f
rtl/core/spta_pkg.sv
rtl/core/spta_item_if.sv
rtl/core/spta_result_if.sv
rtl/core/spta_cfg_if.sv
rtl/core/spta_step.sv
rtl/core/servo_pan_tilt_aim_controller.sv
verif/servo_pan_tilt_aim_controller_test.sv
